/* hdl/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSMG_ASSERT_COMB(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ssmg assertion failed");

// Next-cycle implication.
`define SSMG_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ssmg assertion failed");

`endif

/* hdl/ssmg_pkg.sv */
`default_nettype none

package ssmg_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int COORD_W = 30;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_DUP    = 2'd1,
		STAT_ABSENT = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

/* hdl/ssmg_ram.sv */
`default_nettype none

module ssmg_ram
	import ssmg_pkg::*;
#(
	parameter int WIDTH = COORD_W,
	parameter int DEPTH = CAPACITY_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/sorted_set_span_minus_max_gap.sv */
// channel  signals                 direction  payload
// in       in_valid / in_ready     input      op, coord
// out      out_valid / out_ready   output     answer, status, point_count
//
// The search pass reads stored points in order up to the key's slot; on a change a
// shift pass reads and moves the points from that slot on (past it for a remove);
// then a gap scan reads the new set, one read a cycle, on the memory's single read port.
// Reset clears the point count and all handshake state, not the memory.
// A stalled result holds in the output register while the next item runs; the
// block then waits before loading its own result until that register frees.
`default_nettype none

module sorted_set_span_minus_max_gap
	import ssmg_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             op,
	input  wire logic [COORD_W-1:0]               coord,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [COORD_W-1:0]               answer,
	output logic      [1:0]                       status,
	output logic      [$clog2(CAPACITY+1)-1:0]    point_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic               out_valid_q;
	logic               tag_vld_q;
	logic [AW-1:0]      tag_q;

	op_t                op_q;
	logic [COORD_W-1:0] coord_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      rem_q;
	logic [CW-1:0]      pos_q;
	status_t            status_q;
	logic [COORD_W-1:0] first_q;
	logic [COORD_W-1:0] prev_q;
	logic [COORD_W-1:0] maxgap_q;
	logic [COORD_W-1:0] answer_q;
	status_t            status_out_q;
	logic [CW-1:0]      point_count_q;

	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [COORD_W-1:0] mem_wdata;
	logic [COORD_W-1:0] rd_data;

	logic               hit;
	logic               present;
	logic               search_done;
	logic [CW-1:0]      found_pos;
	state_t             search_next;
	status_t            search_status;
	logic [COORD_W-1:0] gap;

	ssmg_ram #(
		.WIDTH (COORD_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	assign hit         = tag_vld_q && (rd_data >= coord_q);
	assign present     = hit && (rd_data == coord_q);
	assign search_done = hit || (!tag_vld_q && !(idx_q < count_q));
	assign found_pos   = hit ? CW'(tag_q) : count_q;
	assign gap         = rd_data - prev_q;

	always_comb begin
		search_next   = S_SCAN;
		search_status = STAT_OK;
		if (op_q == OP_INSERT) begin
			if (present) begin
				search_status = STAT_DUP;
			end else if (count_q == CW'(CAPACITY)) begin
				search_status = STAT_FULL;
			end else begin
				search_next = S_SHIFT;
			end
		end else begin
			if (!present) begin
				search_status = STAT_ABSENT;
			end else begin
				search_next = S_SHIFT;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = tag_q;
		mem_wdata = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (search_done) begin
					state_d = search_next;
				end else begin
					mem_re = idx_q < count_q;
				end
			end
			S_SHIFT: begin
				if (rem_q != '0) begin
					mem_re = 1'b1;
				end else if (!tag_vld_q) begin
					state_d = S_SCAN;
				end
				if (tag_vld_q) begin
					mem_we    = 1'b1;
					mem_waddr = (op_q == OP_INSERT) ? tag_q + AW'(1) : tag_q - AW'(1);
				end else if (rem_q == '0 && op_q == OP_INSERT) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = coord_q;
				end
			end
			S_SCAN: begin
				if (idx_q < count_q) begin
					mem_re = 1'b1;
				end else if (!tag_vld_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			tag_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			tag_vld_q <= mem_re;
			if (state_q == S_SHIFT && state_d == S_SCAN) begin
				count_q <= (op_q == OP_INSERT) ? count_q + CW'(1) : count_q - CW'(1);
			end
			if (state_q == S_DONE && state_d == S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= mem_raddr;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q    <= op_t'(op);
					coord_q <= coord;
					idx_q   <= '0;
				end
			end
			S_SEARCH: begin
				if (mem_re) begin
					idx_q <= idx_q + CW'(1);
				end else if (search_done) begin
					pos_q    <= found_pos;
					status_q <= search_status;
					maxgap_q <= '0;
					if (search_next == S_SHIFT) begin
						if (op_q == OP_INSERT) begin
							idx_q <= count_q - CW'(1);
							rem_q <= count_q - found_pos;
						end else begin
							idx_q <= found_pos + CW'(1);
							rem_q <= count_q - found_pos - CW'(1);
						end
					end else begin
						idx_q <= '0;
					end
				end
			end
			S_SHIFT: begin
				if (mem_re) begin
					rem_q <= rem_q - CW'(1);
					idx_q <= (op_q == OP_INSERT) ? idx_q - CW'(1) : idx_q + CW'(1);
				end else if (!tag_vld_q) begin
					idx_q <= '0;
				end
			end
			S_SCAN: begin
				if (mem_re) begin
					idx_q <= idx_q + CW'(1);
				end
				if (tag_vld_q) begin
					prev_q <= rd_data;
					if (tag_q == '0) begin
						first_q <= rd_data;
					end else if (gap > maxgap_q) begin
						maxgap_q <= gap;
					end
				end
			end
			S_DONE: begin
				if (state_d == S_IDLE) begin
					answer_q      <= (count_q < CW'(2)) ? '0 : prev_q - first_q - maxgap_q;
					status_out_q  <= status_q;
					point_count_q <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = out_valid_q;
	assign answer      = answer_q;
	assign status      = status_out_q;
	assign point_count = point_count_q;

endmodule

`default_nettype wire

/* hdl/ssmg_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module ssmg_checker
	import ssmg_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [COORD_W-1:0]            answer,
	input wire logic [1:0]                    status,
	input wire logic [$clog2(CAPACITY+1)-1:0] point_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	`SSMG_ASSERT_COMB(a_full_count, out_valid && status == STAT_FULL, point_count == CW'(CAPACITY))
	`SSMG_ASSERT_COMB(a_few_zero, out_valid && point_count < CW'(2), answer == '0)
	`SSMG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`SSMG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(answer))
	`SSMG_ASSERT_NEXT(a_out_fields, out_valid && !out_ready, $stable({status, point_count}))

endmodule

bind sorted_set_span_minus_max_gap ssmg_checker #(.CAPACITY(CAPACITY)) u_ssmg_checker (.*);

`default_nettype wire
